/* rtl/core/sfr_pkg.sv */
package sfr_pkg;

  localparam logic [1:0] CMD_BYTE   = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [2:0] ST_NONE      = 3'd0;
  localparam logic [2:0] ST_ACCEPTED  = 3'd1;
  localparam logic [2:0] ST_CRC_BAD   = 3'd2;
  localparam logic [2:0] ST_NOT_MINE  = 3'd3;
  localparam logic [2:0] ST_DUPLICATE = 3'd4;
  localparam logic [2:0] ST_TOO_LONG  = 3'd5;

  localparam logic       REG_MY_ADDR = 1'b0;
  localparam logic       REG_TIMEOUT = 1'b1;

  localparam logic [7:0] TYPE_PARSED = 8'h19;

  typedef enum logic [7:0] {
    PH_IDLE    = 8'b0000_0001,
    PH_DISCARD = 8'b0000_0010,
    PH_LENGTH  = 8'b0000_0100,
    PH_DEST    = 8'b0000_1000,
    PH_SOURCE  = 8'b0001_0000,
    PH_ID      = 8'b0010_0000,
    PH_PAYLOAD = 8'b0100_0000,
    PH_CRC     = 8'b1000_0000
  } phase_e;

  typedef enum logic [3:0] {
    CT_IDLE = 4'b0001,
    CT_RD   = 4'b0010,
    CT_COPY = 4'b0100,
    CT_OUT  = 4'b1000
  } ctl_e;

  typedef struct packed {
    logic       data_available;
    logic       read_valid;
    logic [7:0] read_data;
    logic [2:0] frame_status;
  } result_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ 8'h8C) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* rtl/core/stuffed_frame_receiver_unit.sv */
// Byte-stuffed frame receiver. Each beat carries a command: a radio byte, a
// millisecond tick or a ring read; each beat yields exactly one result beat.
// A beat is registered, evaluated in the read state and its result registered
// in the output state; a read goes through the ring memory's registered read
// port. The beat that ends an accepted frame copies the payload from the
// payload memory into the ring one byte per cycle before its result is formed.
// Input is held off until the previous result beat has been taken, so one beat
// is in flight at a time.
module stuffed_frame_receiver_unit #(
  parameter int unsigned MAX_PAYLOAD = 128,
  parameter int unsigned RING_DEPTH  = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [1:0] cmd, [9:2] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [2:0] frame_status, [10:3] read_data,
                                      // [11] read_valid, [12] data_available
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import sfr_pkg::*;

  localparam int PW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int RW = $clog2(RING_DEPTH);
  localparam logic [RW-1:0] RING_LAST = RW'(RING_DEPTH - 1);

  logic [7:0]    pay_mem [MAX_PAYLOAD];
  logic [7:0]    ring_mem [RING_DEPTH];

  logic [7:0]    my_addr_q, tmo_q;
  phase_e        ph_q;
  ctl_e          ct_q;
  logic [7:0]    len_q, dest_q, id_q, crc_q, pidx_q, last_id_q, idle_q;
  logic [8:0]    guard_q;
  logic          skip_q;
  logic [RW-1:0] head_q, tail_q;
  logic [1:0]    cmd_q;
  logic [7:0]    byte_q;
  logic [7:0]    cnt_q;
  logic [RW-1:0] pos_q;
  result_t       res_q;
  logic          ovalid_q;
  logic [7:0]    pay_rd_q, ring_rd_q;
  logic          pay_rd_en, ring_rd_en;
  logic [PW-1:0] pay_rd_addr;
  logic [RW-1:0] ring_rd_addr;

  function automatic logic [RW-1:0] rnext(input logic [RW-1:0] p);
    return (p == RING_LAST) ? '0 : p + 1'b1;
  endfunction

  assign s_axis_tready = (ct_q == CT_IDLE) && !ovalid_q;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {3'b0, res_q};

  assign pay_rd_en    = (ct_q == CT_COPY);
  assign pay_rd_addr  = cnt_q[PW-1:0];
  assign ring_rd_en   = (ct_q == CT_RD);
  assign ring_rd_addr = rnext(tail_q);

  always_ff @(posedge clk_i) begin
    if (pay_rd_en) begin
      pay_rd_q <= pay_mem[pay_rd_addr];
    end
    if (ring_rd_en) begin
      ring_rd_q <= ring_mem[ring_rd_addr];
    end
  end

  // byte parse, combinational on registered beat
  phase_e     pp_ph;
  logic [7:0] pp_idle, pp_crc, pp_len, pp_dest, pp_id, pp_pidx;
  logic [8:0] pp_guard;
  logic [2:0] pp_st;
  logic       pp_wr, pp_fin;
  phase_e     ph_eff;
  logic [8:0] g_eff;

  always_comb begin
    ph_eff   = ph_q;
    g_eff    = guard_q;
    pp_idle  = idle_q;
    if (idle_q > tmo_q) begin
      ph_eff  = PH_IDLE;
      g_eff   = '0;
      pp_idle = '0;
    end
    pp_ph   = ph_eff;
    pp_crc  = crc_q;
    pp_len  = len_q;
    pp_dest = dest_q;
    pp_id   = id_q;
    pp_pidx = pidx_q;
    pp_st   = ST_NONE;
    pp_wr   = 1'b0;
    pp_fin  = 1'b0;
    unique case (ph_eff)
      PH_IDLE: begin
        pp_ph   = (byte_q == TYPE_PARSED) ? PH_LENGTH : PH_DISCARD;
        pp_idle = '0;
      end
      PH_DISCARD: pp_ph = PH_IDLE;
      PH_LENGTH: begin
        pp_idle = '0;
        if (9'(byte_q) > 9'(MAX_PAYLOAD)) begin
          pp_st = ST_TOO_LONG;
          pp_ph = PH_IDLE;
        end else begin
          pp_len = byte_q;
          pp_crc = crc8_update(crc8_update(8'h00, TYPE_PARSED), byte_q);
          pp_ph  = PH_DEST;
        end
      end
      PH_DEST: begin
        pp_idle = '0;
        pp_dest = byte_q;
        pp_crc  = crc8_update(crc_q, byte_q);
        pp_ph   = PH_SOURCE;
      end
      PH_SOURCE: begin
        pp_idle = '0;
        pp_crc  = crc8_update(crc_q, byte_q);
        pp_ph   = PH_ID;
      end
      PH_ID: begin
        pp_idle = '0;
        pp_id   = byte_q;
        pp_crc  = crc8_update(crc_q, byte_q);
        pp_pidx = '0;
        pp_ph   = (len_q == 8'd0) ? PH_CRC : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        pp_idle = '0;
        pp_wr   = 9'(pidx_q) < 9'(MAX_PAYLOAD);
        pp_crc  = crc8_update(crc_q, byte_q);
        pp_pidx = pidx_q + 8'd1;
        if (pp_pidx >= len_q) pp_ph = PH_CRC;
      end
      PH_CRC: begin
        pp_idle = '0;
        pp_ph   = PH_IDLE;
        g_eff   = '0;
        if (byte_q != crc_q) pp_st = ST_CRC_BAD;
        else if (dest_q != my_addr_q) pp_st = ST_NOT_MINE;
        else if (id_q == last_id_q) pp_st = ST_DUPLICATE;
        else begin
          pp_st  = ST_ACCEPTED;
          pp_fin = 1'b1;
        end
      end
      default: pp_ph = PH_IDLE;
    endcase
    pp_guard = g_eff + 9'd1;
    if (g_eff == 9'd256) begin
      pp_ph    = PH_IDLE;
      pp_guard = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ct_q == CT_RD && cmd_q == CMD_BYTE && !skip_q && pp_wr) begin
      pay_mem[pidx_q[PW-1:0]] <= byte_q;
    end
    if (ct_q == CT_COPY && cnt_q != 8'd0) begin
      ring_mem[pos_q] <= pay_rd_q;
    end
  end

  logic copy_stop;
  assign copy_stop = (cnt_q == len_q) || (9'(cnt_q) == 9'(MAX_PAYLOAD))
                     || (rnext(pos_q) == tail_q);

  logic parse_en;
  assign parse_en = (cmd_q == CMD_BYTE) && !skip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      my_addr_q <= 8'd0;
      tmo_q     <= 8'd7;
      ph_q      <= PH_IDLE;
      ct_q      <= CT_IDLE;
      len_q     <= '0;
      dest_q    <= '0;
      id_q      <= '0;
      crc_q     <= '0;
      pidx_q    <= '0;
      last_id_q <= 8'hFF;
      idle_q    <= '0;
      guard_q   <= '0;
      skip_q    <= 1'b0;
      head_q    <= '0;
      tail_q    <= '0;
      cmd_q     <= '0;
      byte_q    <= '0;
      cnt_q     <= '0;
      pos_q     <= '0;
      res_q     <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == REG_MY_ADDR) my_addr_q <= cfg_data_i;
        else tmo_q <= cfg_data_i;
      end
      if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
      unique case (ct_q)
        CT_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            cmd_q  <= s_axis_tdata[1:0];
            byte_q <= s_axis_tdata[9:2];
            ct_q   <= CT_RD;
          end
        end
        CT_RD: begin
          res_q.frame_status <= parse_en ? pp_st : ST_NONE;
          res_q.read_valid   <= (cmd_q == CMD_READ) && (head_q != tail_q);
          ct_q               <= (parse_en && pp_fin) ? CT_COPY : CT_OUT;
          case (cmd_q)
            CMD_BYTE: begin
              if (skip_q) begin
                skip_q <= 1'b0;
              end else begin
                skip_q       <= (byte_q == 8'h00) || (byte_q == 8'hFF);
                ph_q         <= pp_ph;
                idle_q       <= pp_idle;
                crc_q        <= pp_crc;
                len_q        <= pp_len;
                dest_q       <= pp_dest;
                id_q         <= pp_id;
                pidx_q       <= pp_pidx;
                guard_q      <= pp_guard;
                if (pp_fin) begin
                  last_id_q <= id_q;
                  cnt_q     <= '0;
                  pos_q     <= head_q;
                end
              end
            end
            CMD_TICK: if (idle_q != 8'hFF) idle_q <= idle_q + 8'd1;
            CMD_READ: if (head_q != tail_q) tail_q <= rnext(tail_q);
            default: ;
          endcase
        end
        CT_COPY: begin
          // pay_rd_q holds entry cnt_q-1; written at pos_q once cnt_q > 0
          if (copy_stop) begin
            head_q <= pos_q;
            ct_q   <= CT_OUT;
          end else begin
            pos_q <= rnext(pos_q);
            cnt_q <= cnt_q + 8'd1;
          end
        end
        CT_OUT: begin
          res_q.read_data      <= res_q.read_valid ? ring_rd_q : 8'd0;
          res_q.data_available <= head_q != tail_q;
          ovalid_q <= 1'b1;
          ct_q     <= CT_IDLE;
        end
        default: ct_q <= CT_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/sfr_checker.sv */
module sfr_unit_sva (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[2:0] <= 3'd5)
    else $error("bad status");
  a_rdata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[11] |-> m_axis_tdata[10:3] == 8'd0)
    else $error("read data without valid");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[11] |-> m_axis_tdata[2:0] == 3'd0)
    else $error("status on read");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
    else $error("early result");
endmodule

bind stuffed_frame_receiver_unit sfr_unit_sva u_sfr_unit_sva (.*);

/* tb/sfr_checker.sv */
`timescale 1ns / 100ps

module sfr_checker
  import sfr_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 128,
  parameter int unsigned RING_DEPTH  = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [15:0] s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [15:0] m_tdata_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  output int          fail_o,
  output int          pending_o
);

  result_t    expected_q[$];

  logic [7:0] my_addr, tmo;
  phase_e     phase;
  logic [7:0] flen, fdest, fid, crc, pidx, last_id, ticks;
  int         guard;
  logic       skip;
  logic [7:0] pay[MAX_PAYLOAD];
  logic [7:0] ring[RING_DEPTH];
  logic [7:0] head, tail;

  assign pending_o = expected_q.size();

  function automatic logic [7:0] crc_fold(logic [7:0] c, logic [7:0] b);
    logic [7:0] r;
    r = c ^ b;
    repeat (8) r = r[0] ? ({1'b0, r[7:1]} ^ 8'h8C) : {1'b0, r[7:1]};
    return r;
  endfunction

  function automatic logic [7:0] ring_inc(logic [7:0] p);
    return (int'(p) + 1 >= RING_DEPTH) ? 8'd0 : p + 8'd1;
  endfunction

  task automatic predict_beat(logic [1:0] cmd, logic [7:0] b);
    result_t    r;
    logic [7:0] pos, nxt;
    r = '0;
    if (cmd == CMD_BYTE) begin
      if (skip) begin
        skip = 1'b0;
      end else begin
        if (b == 8'h00 || b == 8'hFF) skip = 1'b1;
        if (ticks > tmo) begin
          phase = PH_IDLE;
          guard = 0;
          ticks = 0;
        end
        case (phase)
          PH_IDLE: begin
            phase = (b == TYPE_PARSED) ? PH_LENGTH : PH_DISCARD;
            ticks = 0;
          end
          PH_DISCARD: phase = PH_IDLE;
          PH_LENGTH: begin
            ticks = 0;
            if (int'(b) > MAX_PAYLOAD) begin
              r.frame_status = ST_TOO_LONG;
              phase = PH_IDLE;
            end else begin
              flen = b;
              crc = crc_fold(crc_fold(8'h00, TYPE_PARSED), b);
              phase = PH_DEST;
            end
          end
          PH_DEST: begin
            ticks = 0;
            fdest = b;
            crc = crc_fold(crc, b);
            phase = PH_SOURCE;
          end
          PH_SOURCE: begin
            ticks = 0;
            crc = crc_fold(crc, b);
            phase = PH_ID;
          end
          PH_ID: begin
            ticks = 0;
            fid = b;
            crc = crc_fold(crc, b);
            pidx = 0;
            phase = (flen == 0) ? PH_CRC : PH_PAYLOAD;
          end
          PH_PAYLOAD: begin
            ticks = 0;
            if (int'(pidx) < MAX_PAYLOAD) pay[pidx] = b;
            crc = crc_fold(crc, b);
            pidx = pidx + 8'd1;
            if (pidx >= flen) phase = PH_CRC;
          end
          default: begin
            ticks = 0;
            if (b != crc) r.frame_status = ST_CRC_BAD;
            else if (fdest != my_addr) r.frame_status = ST_NOT_MINE;
            else if (fid == last_id) r.frame_status = ST_DUPLICATE;
            else begin
              r.frame_status = ST_ACCEPTED;
              last_id = fid;
              pos = head;
              for (int i = 0; i < int'(flen) && i < MAX_PAYLOAD; i++) begin
                nxt = ring_inc(pos);
                if (nxt == tail) break;
                pos = nxt;
                ring[pos] = pay[i];
              end
              head = pos;
            end
            phase = PH_IDLE;
            guard = 0;
          end
        endcase
        guard++;
        if (guard > 256) begin
          phase = PH_IDLE;
          guard = 0;
        end
      end
    end else if (cmd == CMD_TICK) begin
      if (ticks < 8'd255) ticks = ticks + 8'd1;
    end else if (cmd == CMD_READ) begin
      if (head != tail) begin
        tail = ring_inc(tail);
        r.read_data = ring[tail];
        r.read_valid = 1'b1;
      end
    end
    r.data_available = (head != tail);
    expected_q.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got, want;
    if (!rst_ni) begin
      my_addr = 8'd0;
      tmo = 8'd7;
      phase = PH_IDLE;
      flen = 0; fdest = 0; fid = 0; crc = 0; pidx = 0;
      last_id = 8'd255;
      ticks = 0;
      guard = 0;
      skip = 1'b0;
      head = 0;
      tail = 0;
      fail_o = 0;
      expected_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_MY_ADDR) my_addr = cfg_data_i;
        else tmo = cfg_data_i;
      end
      if (s_tvalid_i && s_tready_i) predict_beat(s_tdata_i[1:0], s_tdata_i[9:2]);
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i[12:0];
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected: %h", m_tdata_i);
          fail_o++;
        end else begin
          want = expected_q.pop_front();
          if (got.frame_status !== want.frame_status) begin
            $error("frame_status expected %0d actual %0d", want.frame_status,
                   got.frame_status);
            fail_o++;
          end
          if (got.read_data !== want.read_data) begin
            $error("read_data expected %h actual %h", want.read_data, got.read_data);
            fail_o++;
          end
          if (got.read_valid !== want.read_valid) begin
            $error("read_valid expected %b actual %b", want.read_valid, got.read_valid);
            fail_o++;
          end
          if (got.data_available !== want.data_available) begin
            $error("data_available expected %b actual %b", want.data_available,
                   got.data_available);
            fail_o++;
          end
        end
      end
    end
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
  import sfr_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [7:0]  cfg_data_i = '0;
  int          fail_cnt, pending_cnt;

  logic [9:0]  beats[$];
  logic [7:0]  cur_addr, cur_tmo;
  int          burst_left = 0;
  int          stall_mode = 0;
  int          cyc = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  stuffed_frame_receiver_unit DUT (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  sfr_checker CHK (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready), .s_tdata_i(s_axis_tdata),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready), .m_tdata_i(m_axis_tdata),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_o(fail_cnt), .pending_o(pending_cnt)
  );

  always @(posedge clk_i) begin
    cyc++;
    if (cyc % 400 == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= $urandom_range(0, 1);
      default: m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  function automatic logic [7:0] crc_next(logic [7:0] c, logic [7:0] b);
    logic [7:0] r;
    r = c ^ b;
    for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ 8'h8C) : (r >> 1);
    return r;
  endfunction

  task automatic add_cmd(logic [1:0] cmd, logic [7:0] b);
    beats.push_back({b, cmd});
  endtask

  // a 00/FF byte is followed by a stuff byte on the air
  task automatic add_byte(logic [7:0] b);
    add_cmd(CMD_BYTE, b);
    if (b == 8'h00 || b == 8'hFF) add_cmd(CMD_BYTE, 8'($urandom));
  endtask

  task automatic add_frame(int len, logic [7:0] dest, logic [7:0] id, bit good, bit cut);
    logic [7:0] c, p;
    int         stop;
    stop = cut ? $urandom_range(1, len + 4) : len + 10;
    add_byte(TYPE_PARSED);
    add_byte(8'(len));
    c = crc_next(crc_next(8'h00, TYPE_PARSED), 8'(len));
    for (int i = 0; i < len + 3; i++) begin
      if (i == stop) begin
        repeat (int'(cur_tmo) + 1) add_cmd(CMD_TICK, 8'($urandom));
        return;
      end
      p = (i == 0) ? dest : 8'($urandom);
      if (i == 2) p = id;
      c = crc_next(c, p);
      add_byte(p);
    end
    add_byte(good ? c : c ^ 8'(1 << $urandom_range(0, 7)));
  endtask

  task automatic send_beats();
    while (beats.size() > 0) begin
      if (burst_left == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        burst_left = $urandom_range(1, 24);
      end
      s_axis_tdata <= {6'd0, beats.pop_front()};
      s_axis_tvalid <= 1'b1;
      do @(posedge clk_i); while (!s_axis_tready);
      burst_left--;
    end
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_MY_ADDR) cur_addr = val;
    else cur_tmo = val;
  endtask

  task automatic random_phase(int target, int read_pct, int long_pct);
    int r, len;
    logic [7:0] last;
    last = 8'($urandom);
    while (beats.size() < target) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        len = ($urandom_range(0, 99) < long_pct) ? $urandom_range(100, 128)
                                                  : $urandom_range(0, 8);
        if ($urandom_range(0, 19) == 0) begin
          add_byte(TYPE_PARSED);
          add_byte(8'($urandom_range(129, 255)));
        end else begin
          if ($urandom_range(0, 4) != 0) last = 8'($urandom);
          add_frame(len, ($urandom_range(0, 4) != 0) ? cur_addr : 8'($urandom), last,
                    $urandom_range(0, 9) != 0, $urandom_range(0, 9) == 0);
        end
      end else if (r < 60 + read_pct) begin
        repeat ($urandom_range(1, 8)) add_cmd(CMD_READ, 8'($urandom));
      end else if (r < 85) begin
        repeat ($urandom_range(1, 3)) add_cmd(CMD_TICK, 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 6))
          add_cmd(($urandom_range(0, 5) == 0) ? CMD_UNUSED : CMD_BYTE, 8'($urandom));
      end
    end
    send_beats();
    drain();
  endtask

  initial begin
    #20000000;
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    cur_addr = 8'd0;
    cur_tmo = 8'd7;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty read, zero length, bad crc, not mine, duplicate, too long,
    // other type, tick, unused cmd
    add_cmd(CMD_READ, 8'h00);
    add_frame(0, 8'h00, 8'h01, 1, 0);
    add_frame(2, 8'h00, 8'h02, 1, 0);
    add_cmd(CMD_READ, 8'hFF);
    add_cmd(CMD_READ, 8'h00);
    add_cmd(CMD_READ, 8'h00);
    send_beats();
    add_frame(1, 8'h00, 8'h03, 0, 0);
    add_frame(1, 8'h44, 8'h04, 1, 0);
    add_frame(1, 8'h00, 8'h02, 1, 0);
    add_byte(TYPE_PARSED);
    add_byte(8'hFF);
    add_byte(8'h7E);
    add_byte(8'h55);
    add_cmd(CMD_TICK, 8'hFF);
    add_cmd(CMD_UNUSED, 8'hAA);
    send_beats();
    drain();

    random_phase(300, 15, 3);
    write_reg(REG_MY_ADDR, 8'hFF);
    write_reg(REG_TIMEOUT, 8'd0);
    random_phase(300, 15, 3);
    // no reads: fill the ring past its depth
    write_reg(REG_MY_ADDR, 8'h5A);
    write_reg(REG_TIMEOUT, 8'd255);
    random_phase(400, 0, 30);
    write_reg(REG_MY_ADDR, 8'($urandom));
    write_reg(REG_TIMEOUT, 8'($urandom_range(1, 20)));
    random_phase(350, 20, 5);

    if (fail_cnt == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule
